// ===== design/argbu_pkg.sv =====
// shared types, constants and helpers for the argb un-premultiply pipeline
// no dependencies; used by every module in the design folder
package argbu_pkg;

   localparam int BYTE_W      = 8;
   localparam int NUM_W       = 16;
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int PROD_W      = NUM_W + RECIP_W;
   localparam int ALPHA_CODES = 256;
   localparam int RECIP_ONE   = 1 << RECIP_SHIFT;

   localparam logic [BYTE_W-1:0] ALPHA_CLEAR  = 8'h00;
   localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hff;
   localparam logic              HAS_ALPHA_RESET = 1'b1;

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [NUM_W-1:0]   num_type;
   typedef logic [RECIP_W-1:0] recip_type;
   typedef logic [PROD_W-1:0]  prod_type;

   // one pixel as it travels down the pipe, with the mode it was taken in
   typedef struct packed {
      logic     has_alpha;
      byte_type alpha;
      byte_type red;
      byte_type green;
      byte_type blue;
      logic     row_last;
   } pixel_type;

   typedef struct packed {
      pixel_type pix;
      num_type   num_red;
      num_type   num_green;
      num_type   num_blue;
      recip_type recip;
   } front_type;

   typedef struct packed {
      pixel_type pix;
      byte_type  quot_red;
      byte_type  quot_green;
      byte_type  quot_blue;
   } quot_type;

   // c*255 + alpha/2, at most 65152
   function automatic num_type unpremul_num(input byte_type c, input byte_type a);
      num_type c_wide;
      num_type half_a;
      c_wide = {8'b0, c};
      half_a = {9'b0, a[BYTE_W-1:1]};
      return (c_wide << BYTE_W) - c_wide + half_a;
   endfunction

endpackage

// ===== design/argbu_front.sv =====
// first stage: reciprocal lookup of alpha and rounded numerators per channel
// depends on argbu_pkg
module argbu_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  argbu_pkg::pixel_type  in_pix,
   output logic                  in_ready,
   output logic                  out_valid,
   input  logic                  out_ready,
   output argbu_pkg::front_type  out_data
);

   // ceil(2^24 / a): exact floor quotient for every numerator below 2^16
   argbu_pkg::recip_type recip_rom [argbu_pkg::ALPHA_CODES];

   for (genvar i = 0; i < argbu_pkg::ALPHA_CODES; i++) begin : g_recip
      localparam int Divisor = (i == 0) ? 1 : i;
      localparam argbu_pkg::recip_type RecipVal =
         argbu_pkg::recip_type'((argbu_pkg::RECIP_ONE + Divisor - 1) / Divisor);
      assign recip_rom[i] = RecipVal;
   end

   logic                 valid_ff;
   argbu_pkg::front_type data_ff;
   argbu_pkg::front_type data_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      data_in.pix       = in_pix;
      data_in.num_red   = argbu_pkg::unpremul_num(in_pix.red, in_pix.alpha);
      data_in.num_green = argbu_pkg::unpremul_num(in_pix.green, in_pix.alpha);
      data_in.num_blue  = argbu_pkg::unpremul_num(in_pix.blue, in_pix.alpha);
      data_in.recip     = recip_rom[in_pix.alpha];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== design/argbu_divide.sv =====
// second stage: multiply numerators by the alpha reciprocal, keep low quotient byte
// depends on argbu_pkg
module argbu_divide (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  argbu_pkg::front_type  in_data,
   output logic                  in_ready,
   output logic                  out_valid,
   input  logic                  out_ready,
   output argbu_pkg::quot_type   out_data
);

   logic                 valid_ff;
   argbu_pkg::quot_type  data_ff;
   argbu_pkg::quot_type  data_in;
   argbu_pkg::prod_type  prod_red;
   argbu_pkg::prod_type  prod_green;
   argbu_pkg::prod_type  prod_blue;
   argbu_pkg::prod_type  recip_wide;

   assign in_ready = !valid_ff || out_ready;

   assign recip_wide = {{argbu_pkg::NUM_W{1'b0}}, in_data.recip};
   assign prod_red   = {{argbu_pkg::RECIP_W{1'b0}}, in_data.num_red} * recip_wide;
   assign prod_green = {{argbu_pkg::RECIP_W{1'b0}}, in_data.num_green} * recip_wide;
   assign prod_blue  = {{argbu_pkg::RECIP_W{1'b0}}, in_data.num_blue} * recip_wide;

   always_comb begin
      data_in.pix        = in_data.pix;
      data_in.quot_red   = prod_red[argbu_pkg::RECIP_SHIFT +: argbu_pkg::BYTE_W];
      data_in.quot_green = prod_green[argbu_pkg::RECIP_SHIFT +: argbu_pkg::BYTE_W];
      data_in.quot_blue  = prod_blue[argbu_pkg::RECIP_SHIFT +: argbu_pkg::BYTE_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== design/argb_unpremultiply_to_rgba.sv =====
// top level: config register, output select stage and pipeline handshake
// depends on argbu_pkg, argbu_front and argbu_divide
//
// Takes one premultiplied ARGB pixel word (A[31:24] R[23:16] G[15:8] B[7:0])
// per request and returns its R, G, B bytes plus a fourth byte. With has_alpha
// set (the reset value) each colour is un-premultiplied as
// (c*255 + a/2) / a, low 8 bits kept with no saturation; alpha 0 gives all
// zeros and alpha 255 passes colour through. With has_alpha clear the bytes
// are unpacked and the top byte goes straight to the fourth byte. row_last is
// carried alongside. The pipe is three registers deep: reciprocal lookup and
// numerators, then the reciprocal multiply, then the output select register.
// A request is accepted every clock while rsp_stall is low; each result goes
// from the front register to the divide register, then to the output register,
// where it can be taken. Throughput is one pixel per clock while rsp_stall is
// low, as every stage then takes a new pixel each cycle. A stall backs up stage
// by stage, and req_stall rises only once all three stages are full.
// has_alpha is sampled with each pixel and should only be written while the
// pipe is empty.
module argb_unpremultiply_to_rgba (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_write_en,
   input  logic        csr_write_data,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_pixel_word,
   input  logic        req_row_last,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   output logic [7:0]  rsp_fourth_out,
   output logic        rsp_row_last_out
);

   // mode register
   logic has_alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         has_alpha_ff <= argbu_pkg::HAS_ALPHA_RESET;
      end else if (csr_write_en) begin
         has_alpha_ff <= csr_write_data;
      end
   end

   // split the pixel word into bytes and tag it with the current mode
   argbu_pkg::pixel_type req_pix;

   always_comb begin
      req_pix.has_alpha = has_alpha_ff;
      req_pix.alpha     = req_pixel_word[31:24];
      req_pix.red       = req_pixel_word[23:16];
      req_pix.green     = req_pixel_word[15:8];
      req_pix.blue      = req_pixel_word[7:0];
      req_pix.row_last  = req_row_last;
   end

   // stage one: reciprocal and numerators
   logic                 front_in_ready;
   logic                 front_valid;
   argbu_pkg::front_type front_data;

   // stage two: multiply
   logic                 divide_in_ready;
   logic                 divide_valid;
   argbu_pkg::quot_type  divide_data;

   // stage three: output register
   logic                 out_ready;
   logic                 rsp_valid_ff;
   logic                 out_has_alpha_ff;
   argbu_pkg::byte_type  red_ff, green_ff, blue_ff, fourth_ff;
   argbu_pkg::byte_type  red_in, green_in, blue_in, fourth_in;
   logic                 row_last_ff;

   argbu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_pix    (req_pix),
      .in_ready  (front_in_ready),
      .out_valid (front_valid),
      .out_ready (divide_in_ready),
      .out_data  (front_data)
   );

   argbu_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .in_ready  (divide_in_ready),
      .out_valid (divide_valid),
      .out_ready (out_ready),
      .out_data  (divide_data)
   );

   // the output register frees as soon as its result is taken
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !front_in_ready;

   // pick quotient, pass-through or zero depending on mode and alpha
   always_comb begin
      red_in    = divide_data.pix.red;
      green_in  = divide_data.pix.green;
      blue_in   = divide_data.pix.blue;
      fourth_in = divide_data.pix.alpha;
      if (divide_data.pix.has_alpha) begin
         if (divide_data.pix.alpha == argbu_pkg::ALPHA_CLEAR) begin
            red_in    = '0;
            green_in  = '0;
            blue_in   = '0;
            fourth_in = argbu_pkg::ALPHA_CLEAR;
         end else if (divide_data.pix.alpha != argbu_pkg::ALPHA_OPAQUE) begin
            red_in   = divide_data.quot_red;
            green_in = divide_data.quot_green;
            blue_in  = divide_data.quot_blue;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= divide_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && divide_valid) begin
         red_ff           <= red_in;
         green_ff         <= green_in;
         blue_ff          <= blue_in;
         fourth_ff        <= fourth_in;
         row_last_ff      <= divide_data.pix.row_last;
         out_has_alpha_ff <= divide_data.pix.has_alpha;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_red_out      = red_ff;
   assign rsp_green_out    = green_ff;
   assign rsp_blue_out     = blue_ff;
   assign rsp_fourth_out   = fourth_ff;
   assign rsp_row_last_out = row_last_ff;

   // back-pressure only reaches the input once every stage holds a pixel
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (front_valid && divide_valid && rsp_valid_ff && rsp_stall))
      else $error("input stalled with room in the pipe");

   // zero alpha in alpha mode must give zero colour
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && out_has_alpha_ff && rsp_fourth_out == argbu_pkg::ALPHA_CLEAR) |->
      (rsp_red_out == '0 && rsp_green_out == '0 && rsp_blue_out == '0))
      else $error("transparent pixel has non-zero colour");

   // mode comes out of reset in alpha mode
   assert property (@(posedge clock)
      ($past(reset) && !reset) |-> has_alpha_ff == argbu_pkg::HAS_ALPHA_RESET)
      else $error("mode register not at its reset value");

   // a result taken with nothing behind it leaves the output empty
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !divide_valid) |=> !rsp_valid)
      else $error("result repeated after being taken");

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for argb_unpremultiply_to_rgba
// depends on argbu_pkg and the design folder; predicts every pixel and checks each result
`timescale 1ns / 1ps

module tb;

   // alpha mode codes for the single csr bit
   localparam logic MODE_OPAQUE = 1'b0;
   localparam logic MODE_ALPHA  = 1'b1;

   localparam int MAX_GAP     = 8;
   localparam int PIPE_DEPTH  = 3;
   localparam int PRINT_LIMIT = 40;

   // one expected result, in port order
   typedef struct packed {
      argbu_pkg::byte_type red;
      argbu_pkg::byte_type green;
      argbu_pkg::byte_type blue;
      argbu_pkg::byte_type fourth;
      logic                row_last;
   } rgba_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_en = 1'b0;
   logic        csr_write_data = 1'b0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_pixel_word = '0;
   logic        req_row_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_red_out;
   logic [7:0]  rsp_green_out;
   logic [7:0]  rsp_blue_out;
   logic [7:0]  rsp_fourth_out;
   logic        rsp_row_last_out;

   // testbench copy of the has_alpha register
   logic     alpha_mode = argbu_pkg::HAS_ALPHA_RESET;
   rgba_type expected_rgba[$];
   int       error_count = 0;
   // idle controls: quiet flags switch off random gaps, hold asks for one long stall
   bit       req_quiet = 1'b0;
   bit       rsp_quiet = 1'b0;
   int       rsp_hold_cycles = 0;

   argb_unpremultiply_to_rgba u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel_word   (req_pixel_word),
      .req_row_last     (req_row_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_fourth_out   (rsp_fourth_out),
      .rsp_row_last_out (rsp_row_last_out)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- prediction

   // (c*255 + a/2) / a for alpha 1..254, only the low byte survives, no saturation
   function automatic argbu_pkg::byte_type restore_channel(input argbu_pkg::byte_type c,
                                                           input argbu_pkg::byte_type a);
      int unsigned scaled;
      int unsigned quot;
      scaled = int'(c) * 255 + (int'(a) >> 1);
      quot   = scaled / int'(a);
      return quot[7:0];
   endfunction

   function automatic rgba_type unpremultiply_pixel(input logic [31:0] word,
                                                    input logic last,
                                                    input logic mode);
      rgba_type            res;
      argbu_pkg::byte_type a;
      a = word[31:24];
      res.row_last = last;
      if (mode == MODE_OPAQUE) begin
         // top byte is never looked at, it just rides along
         res.red    = word[23:16];
         res.green  = word[15:8];
         res.blue   = word[7:0];
         res.fourth = a;
      end else if (a == argbu_pkg::ALPHA_CLEAR) begin
         // fully transparent: colour is thrown away
         res.red    = '0;
         res.green  = '0;
         res.blue   = '0;
         res.fourth = '0;
      end else if (a == argbu_pkg::ALPHA_OPAQUE) begin
         res.red    = word[23:16];
         res.green  = word[15:8];
         res.blue   = word[7:0];
         res.fourth = argbu_pkg::ALPHA_OPAQUE;
      end else begin
         res.red    = restore_channel(word[23:16], a);
         res.green  = restore_channel(word[15:8], a);
         res.blue   = restore_channel(word[7:0], a);
         res.fourth = a;
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- helpers

   task automatic report_mismatch(input string what);
      if (error_count < PRINT_LIMIT)
         $display("[%0t] mismatch: %s", $time, what);
      error_count++;
   endtask

   function automatic int draw_gap(input bit quiet);
      if (quiet)
         return 0;
      return $urandom_range(0, MAX_GAP);
   endfunction

   // offers one request, returns at the edge where it was taken; the prediction
   // is made there with the mode in force
   task automatic send_pixel(input logic [31:0] word, input logic last);
      int gap;
      gap = draw_gap(req_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_pixel_word <= word;
      req_row_last   <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rgba.push_back(unpremultiply_pixel(word, last, alpha_mode));
   endtask

   // stop requesting and let every outstanding result come back
   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (expected_rgba.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 1) @(posedge clock);
   endtask

   // only called with the pipe empty
   task automatic set_mode(input logic mode);
      csr_write_en   <= 1'b1;
      csr_write_data <= mode;
      @(posedge clock);
      csr_write_en <= 1'b0;
      alpha_mode = mode;
   endtask

   // mostly well-formed premultiplied pixels (colour no larger than alpha),
   // with a share of clear, opaque and colour-above-alpha words
   function automatic logic [31:0] random_pixel();
      int                  pick;
      argbu_pkg::byte_type a;
      logic [31:0]         word;
      pick = $urandom_range(0, 9);
      a    = argbu_pkg::byte_type'($urandom_range(0, 255));
      if (pick == 0)
         a = argbu_pkg::ALPHA_CLEAR;
      else if (pick == 1)
         a = argbu_pkg::ALPHA_OPAQUE;
      if (pick <= 6)
         word = {a, argbu_pkg::byte_type'($urandom_range(0, a)),
                 argbu_pkg::byte_type'($urandom_range(0, a)),
                 argbu_pkg::byte_type'($urandom_range(0, a))};
      else
         word = {a, 24'($urandom())};
      return word;
   endfunction

   // ---------------------------------------------------------------- result side

   // stalls at random, takes the long hold when asked, and checks each result
   initial begin : result_side
      int       stall_cycles;
      rgba_type want;
      wait (reset == 1'b0);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         stall_cycles = draw_gap(rsp_quiet);
         if (stall_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (expected_rgba.size() == 0) begin
            report_mismatch("result with no request outstanding");
         end else begin
            want = expected_rgba.pop_front();
            if (rsp_red_out !== want.red)
               report_mismatch($sformatf("red got %h want %h", rsp_red_out, want.red));
            if (rsp_green_out !== want.green)
               report_mismatch($sformatf("green got %h want %h", rsp_green_out, want.green));
            if (rsp_blue_out !== want.blue)
               report_mismatch($sformatf("blue got %h want %h", rsp_blue_out, want.blue));
            if (rsp_fourth_out !== want.fourth)
               report_mismatch($sformatf("fourth got %h want %h", rsp_fourth_out, want.fourth));
            if (rsp_row_last_out !== want.row_last)
               report_mismatch($sformatf("row_last got %b want %b",
                                         rsp_row_last_out, want.row_last));
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // alpha mode straight after reset: clear, opaque, tiny alpha with wrap,
   // exact halves and colour above alpha
   task automatic test_alpha_corners();
      send_pixel(32'h0000_0000, 1'b0);
      send_pixel(32'h00ff_ffff, 1'b1);   // clear alpha hides full colour
      send_pixel(32'hff12_3456, 1'b0);
      send_pixel(32'hffff_ffff, 1'b1);
      send_pixel(32'h0101_0101, 1'b0);   // alpha one, colour one gives 255
      send_pixel(32'h01ff_ffff, 1'b0);   // quotient far above 255, low byte kept
      send_pixel(32'hfefe_80fe, 1'b1);
      send_pixel(32'h8080_8080, 1'b0);   // rounding on the half
      send_pixel(32'h80ff_0000, 1'b0);   // colour above alpha
      send_pixel(32'h0201_0000, 1'b1);
      send_pixel(32'h7f3f_1f0f, 1'b0);
      send_pixel(32'hc0c0_8040, 1'b1);
      drain_pipe();
   endtask

   // xrgb unpack: the top byte must come through untouched
   task automatic test_opaque_corners();
      set_mode(MODE_OPAQUE);
      send_pixel(32'h0000_0000, 1'b0);
      send_pixel(32'hffff_ffff, 1'b1);
      send_pixel(32'h00ab_cdef, 1'b0);
      send_pixel(32'h8012_3456, 1'b0);
      send_pixel(32'h7fed_cba9, 1'b1);
      send_pixel(32'h01fe_fefe, 1'b0);
      drain_pipe();
   endtask

   // receiver holds off for a long stretch while requests keep coming,
   // so the pipe fills and req_stall has to rise
   task automatic test_back_pressure();
      set_mode(MODE_ALPHA);
      req_quiet = 1'b1;
      rsp_quiet = 1'b1;
      rsp_hold_cycles = 60;
      repeat (40) send_pixel(random_pixel(), 1'($urandom_range(0, 1)));
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
      drain_pipe();
   endtask

   // random pixels in one mode, with stretches of back-to-back traffic
   task automatic test_random_stream(input logic mode, input int count);
      set_mode(mode);
      for (int i = 0; i < count; i++) begin
         if (i % 64 == 0) begin
            req_quiet = ($urandom_range(0, 3) == 0);
            rsp_quiet = ($urandom_range(0, 3) == 0);
         end
         send_pixel(random_pixel(), 1'($urandom_range(0, 1)));
      end
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
      drain_pipe();
   endtask

   initial begin : run_tests
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_alpha_corners();
      test_opaque_corners();
      test_back_pressure();
      test_random_stream(MODE_ALPHA, 800);
      test_random_stream(MODE_OPAQUE, 400);
      test_random_stream(MODE_ALPHA, 700);
      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (expected_rgba.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_rgba.size()));
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin : watchdog
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
